// ===== rtl/core/modexp_pkg.sv =====
// Package for the modular exponentiation block: word width, register codes
// and the request/response types between the sequencer and the multiplier.
// No dependencies.
`default_nettype none

package modexp_pkg;

  // Width of base, result, modulus and exponent.
  localparam int unsigned WORD_BITS = 32;
  // Bits of a counter that indexes one bit of a word.
  localparam int unsigned CNT_BITS = $clog2(WORD_BITS);
  // Width of the configuration register index.
  localparam int unsigned CFG_IDX_BITS = 2;

  typedef logic [WORD_BITS-1:0] word_t;
  // Modulus with one extra bit, so that a written zero stands for 2^WORD_BITS.
  typedef logic [WORD_BITS:0]   mod_t;
  typedef logic [CNT_BITS-1:0]  cnt_t;

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] REG_MODULUS  = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_EXPONENT = CFG_IDX_BITS'(1);

  // Index of the most significant bit of a word.
  localparam cnt_t LAST_BIT = CNT_BITS'(WORD_BITS - 1);

  // One modular multiply request: p = (a * b) mod m, with a below m.
  typedef struct packed {
    logic  start;
    word_t a;
    word_t b;
  } mm_req_t;

  // Multiply response: done pulses for one cycle, p holds until next start.
  typedef struct packed {
    logic  done;
    word_t p;
  } mm_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/core/modexp_mulmod.sv =====
// Bit-serial modular multiplier, p = (a * b) mod m, built around one shared
// add-and-reduce unit. Depends on modexp_pkg.
`default_nettype none

module modexp_mulmod import modexp_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire mod_t    mod_i,
  input  wire mm_req_t req_i,
  output mm_rsp_t      rsp_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DBL,
    S_ADD
  } state_e;

  state_e state_q;
  cnt_t   cnt_q;
  word_t  r_q;
  word_t  a_q;
  word_t  b_q;
  logic   done_q;

  // Shared unit: (x + y) mod m for x, y below m.
  word_t                add_x;
  logic [WORD_BITS:0]   add_sum;
  logic [WORD_BITS+1:0] add_diff;
  word_t                add_res;

  always_comb begin
    add_x    = (state_q == S_ADD) ? a_q : r_q;
    add_sum  = {1'b0, r_q} + {1'b0, add_x};
    add_diff = {1'b0, add_sum} - {1'b0, mod_i};
    add_res  = add_diff[WORD_BITS+1] ? add_sum[WORD_BITS-1:0] : add_diff[WORD_BITS-1:0];
  end

  // Sequencer: per multiplier bit, from the top, double then add a if the bit is set.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          done_q <= 1'b0;
          if (req_i.start) begin
            a_q     <= req_i.a;
            b_q     <= req_i.b;
            r_q     <= '0;
            cnt_q   <= LAST_BIT;
            state_q <= S_DBL;
          end
        end
        S_DBL: begin
          r_q    <= add_res;
          done_q <= !b_q[cnt_q] && (cnt_q == '0);
          if (b_q[cnt_q]) begin
            state_q <= S_ADD;
          end else if (cnt_q == '0) begin
            state_q <= S_IDLE;
          end else begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
        S_ADD: begin
          r_q    <= add_res;
          done_q <= (cnt_q == '0);
          if (cnt_q == '0) begin
            state_q <= S_IDLE;
          end else begin
            cnt_q   <= cnt_q - 1'b1;
            state_q <= S_DBL;
          end
        end
        default: begin
          done_q  <= 1'b0;
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.p    = r_q;

endmodule

`default_nettype wire

// ===== rtl/core/modular_exponentiation.sv =====
// Modular exponentiation: result = base^exponent mod modulus by square-and-multiply
// over a shared bit-serial modular multiplier. Work per base: one base reduction plus one
// square per exponent bit (the top one skipped), one multiply per set bit and a pass
// through the decision state for each exponent bit.
// One transaction at a time; the output register lets a result wait while the next
// base is taken. Reset sets modulus and exponent to 1 and empties the output register.
`default_nettype none

module modular_exponentiation import modexp_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  // Input channel
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire word_t                   base_i,
  // Output channel
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output word_t                        result_o,
  // Configuration write channel
  input  wire logic                    cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_index_i,
  input  wire word_t                   cfg_data_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RED,
    ST_STEP,
    ST_MUL,
    ST_SQR,
    ST_FINISH
  } state_e;

  state_e  state_q;
  word_t   modulus_q;
  word_t   exponent_q;
  word_t   acc_q;
  word_t   pow_q;
  cnt_t    bit_q;
  mm_req_t req_q;
  mm_req_t req_d;
  mm_rsp_t rsp;
  logic    out_valid_q;
  logic    out_valid_d;
  word_t   result_q;

  // Modulus zero stands for 2^WORD_BITS; one in the residue ring is zero for modulus one.
  mod_t  mod_ext;
  word_t one_mod;
  logic  last_bit;
  logic  out_free;

  assign mod_ext  = {(modulus_q == '0), modulus_q};
  assign one_mod  = (modulus_q == WORD_BITS'(1)) ? '0 : WORD_BITS'(1);
  assign last_bit = (bit_q == LAST_BIT);
  assign out_free = !out_valid_q || !out_stall_i;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q  <= WORD_BITS'(1);
      exponent_q <= WORD_BITS'(1);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_MODULUS:  modulus_q  <= cfg_data_i;
        REG_EXPONENT: exponent_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Shared modular multiplier.
  modexp_mulmod u_mulmod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .mod_i  (mod_ext),
    .req_i  (req_q),
    .rsp_o  (rsp)
  );

  // Multiplier requests and output valid: a start lasts one cycle, and the output
  // register empties on a transaction and fills when the sequencer finishes.
  always_comb begin
    req_d = '{start: 1'b0, a: req_q.a, b: req_q.b};
    unique case (state_q)
      ST_IDLE: begin
        // base mod m as (1 mod m) * base
        if (in_valid_i) req_d = '{start: 1'b1, a: one_mod, b: base_i};
      end
      ST_STEP: begin
        if (exponent_q[bit_q]) begin
          req_d = '{start: 1'b1, a: acc_q, b: pow_q};
        end else if (!last_bit) begin
          req_d = '{start: 1'b1, a: pow_q, b: pow_q};
        end
      end
      ST_MUL: begin
        if (rsp.done && !last_bit) req_d = '{start: 1'b1, a: pow_q, b: pow_q};
      end
      default: ;
    endcase

    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    if (state_q == ST_FINISH && out_free) out_valid_d = 1'b1;
  end

  // Sequencer: reduce the base, then walk the exponent bits from the bottom.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      req_q       <= '0;
      out_valid_q <= 1'b0;
      bit_q       <= '0;
    end else begin
      req_q       <= req_d;
      out_valid_q <= out_valid_d;
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            acc_q   <= one_mod;
            bit_q   <= '0;
            state_q <= ST_RED;
          end
        end
        ST_RED: begin
          if (rsp.done) begin
            pow_q   <= rsp.p;
            state_q <= ST_STEP;
          end
        end
        ST_STEP: begin
          if (exponent_q[bit_q]) begin
            state_q <= ST_MUL;
          end else if (last_bit) begin
            state_q <= ST_FINISH;
          end else begin
            state_q <= ST_SQR;
          end
        end
        ST_MUL: begin
          if (rsp.done) begin
            acc_q <= rsp.p;
            if (last_bit) begin
              state_q <= ST_FINISH;
            end else begin
              state_q <= ST_SQR;
            end
          end
        end
        ST_SQR: begin
          if (rsp.done) begin
            pow_q   <= rsp.p;
            bit_q   <= bit_q + 1'b1;
            state_q <= ST_STEP;
          end
        end
        ST_FINISH: begin
          // Hand the result over once the output register is free.
          if (out_free) begin
            result_q <= acc_q;
            state_q  <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

endmodule

`default_nettype wire

// ===== tb/tb_modular_exponentiation.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for modular_exponentiation: directed table, then random phases.
// Depends on modexp_pkg and the modular_exponentiation RTL; needs nothing else.

module tb_modular_exponentiation;
  import modexp_pkg::*;

  localparam int unsigned IDLE_PCT        = 13;
  localparam int unsigned RESET_CYCLES    = 12;
  localparam int unsigned HOLD_CYCLES     = 10000;
  localparam int unsigned DRAIN_CYCLES    = 5000;
  localparam int unsigned WATCHDOG_LIMIT  = 60000;
  localparam int unsigned NUM_PHASES      = 9;
  localparam int unsigned ITEMS_PER_PHASE = 28;
  localparam int unsigned HOLD_PHASE      = 2;
  localparam int unsigned QUIET_PHASE     = 5;
  localparam int unsigned PAUSE_PHASE     = 7;
  localparam int unsigned PLAN_LEN        = 34;

  // Indexes past the register list; the block must ignore writes there.
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_A = CFG_IDX_BITS'(2);
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_B = CFG_IDX_BITS'(3);

  // One row of the directed table: a register write or a base, with an
  // optional result that is obvious without any arithmetic.
  typedef struct packed {
    logic                    is_cfg;
    logic [CFG_IDX_BITS-1:0] index;
    word_t                   value;
    logic                    known;
    word_t                   result;
  } plan_row_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_stall_o;
  word_t                   base_i;
  logic                    out_valid_o;
  logic                    out_stall_i;
  word_t                   result_o;
  logic                    cfg_valid_i;
  logic                    cfg_ready_o;
  logic [CFG_IDX_BITS-1:0] cfg_index_i;
  word_t                   cfg_data_i;

  // Register copies as the block should hold them.
  word_t model_modulus  = word_t'(1);
  word_t model_exponent = word_t'(1);

  // Results still owed by the block, oldest first.
  word_t pending_results [$];

  logic  known_valid;
  word_t known_result;
  logic  quiet;
  logic  hold_req;
  int    hold_left;
  int    items_accepted;
  int    results_seen;
  int    cfg_writes;
  int    errors;
  int    silent_cycles;

  modular_exponentiation dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .base_i      (base_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (result_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // Clock with a 4 ns period.
  initial clk_i = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Expected b^e mod m by square-and-multiply with exact 64-bit products.
  // A modulus of zero stands for 2^WORD_BITS, which turns into plain wrapping.
  function automatic word_t power_mod(word_t b, word_t e, word_t m);
    logic [63:0] span;
    logic [63:0] acc;
    logic [63:0] sq;
    if (m == word_t'(1)) return '0;
    span = (m == '0) ? (64'd1 << WORD_BITS) : 64'(m);
    acc  = 64'd1;
    sq   = 64'(b) % span;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (e[i]) acc = (acc * sq) % span;
      sq = (sq * sq) % span;
    end
    return acc[WORD_BITS-1:0];
  endfunction

  function automatic plan_row_t reg_write(logic [CFG_IDX_BITS-1:0] idx, word_t data);
    plan_row_t r;
    r        = '0;
    r.is_cfg = 1'b1;
    r.index  = idx;
    r.value  = data;
    return r;
  endfunction

  function automatic plan_row_t base_row(word_t b);
    plan_row_t r;
    r       = '0;
    r.value = b;
    return r;
  endfunction

  function automatic plan_row_t base_known(word_t b, word_t res);
    plan_row_t r;
    r        = '0;
    r.value  = b;
    r.known  = 1'b1;
    r.result = res;
    return r;
  endfunction

  // Directed table: reset values, modulus one, exponent zero, unreduced bases,
  // the wrapping 2^32 modulus, the largest moduli and ignored register indexes.
  plan_row_t directed_plan [PLAN_LEN] = '{
    base_known(32'd0, 32'd0),
    base_known(32'hFFFF_FFFF, 32'd0),
    reg_write(REG_EXPONENT, 32'd0),
    base_known(32'd5, 32'd0),
    reg_write(REG_MODULUS, 32'd3233),
    reg_write(REG_EXPONENT, 32'd17),
    base_row(32'd65),
    base_row(32'd3298),
    base_row(32'hFFFF_FFFF),
    base_row(32'd3232),
    reg_write(REG_EXPONENT, 32'd0),
    base_known(32'd123, 32'd1),
    base_known(32'hFFFF_FFFF, 32'd1),
    reg_write(REG_MODULUS, 32'd0),
    reg_write(REG_EXPONENT, 32'hFFFF_FFFF),
    base_known(32'hFFFF_FFFF, 32'hFFFF_FFFF),
    base_known(32'd2, 32'd0),
    base_known(32'd0, 32'd0),
    base_row(32'd3),
    reg_write(REG_MODULUS, 32'hFFFF_FFFF),
    base_known(32'hFFFF_FFFE, 32'hFFFF_FFFE),
    base_known(32'd1, 32'd1),
    base_known(32'd0, 32'd0),
    reg_write(REG_MODULUS, 32'hFFFF_FFFB),
    reg_write(REG_EXPONENT, 32'hFFFF_FFFA),
    base_known(32'd2, 32'd1),
    base_row(32'hDEAD_BEEF),
    reg_write(REG_SPARE_A, 32'd7),
    reg_write(REG_SPARE_B, 32'hFFFF_FFFF),
    base_row(32'd7),
    reg_write(REG_MODULUS, 32'd2),
    reg_write(REG_EXPONENT, 32'h8000_0000),
    base_known(32'd3, 32'd1),
    base_known(32'd4, 32'd0)
  };

  // The first phases force the extremes; later ones draw a kind at random.
  function automatic word_t pick_modulus(int p);
    int kind;
    kind = (p < 6) ? p : int'($urandom_range(5));
    case (kind)
      0:       return '1;
      1:       return '0;
      2:       return word_t'($urandom_range(1000, 2));
      3:       return word_t'($urandom);
      4:       return word_t'(1);
      default: return word_t'($urandom_range(16'hFFFF, 2));
    endcase
  endfunction

  function automatic word_t pick_exponent(int p);
    int kind;
    kind = (p < 5) ? (p + 2) % 5 : int'($urandom_range(4));
    case (kind)
      0:       return '0;
      1:       return word_t'(1);
      2:       return '1;
      3:       return word_t'($urandom_range(64, 2));
      default: return word_t'($urandom);
    endcase
  endfunction

  // Zero, all ones and bases near the modulus have their own cases; the rest are uniform words.
  function automatic word_t pick_base();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return word_t'(model_modulus - 1);
      3:       return model_modulus;
      4:       return word_t'(model_modulus + $urandom_range(1000));
      default: return word_t'($urandom);
    endcase
  endfunction

  // Offer one base and hold it until the block takes it.
  task automatic offer_base(word_t b, logic has_known, word_t res);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    base_i       <= b;
    known_valid  <= has_known;
    known_result <= res;
    do @(posedge clk_i); while (in_stall_o);
    items_accepted++;
  endtask

  // Wait for every owed result, then write one register.
  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, word_t data);
    while (results_seen != items_accepted) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // Receiver: random stalls, one long hold-off on request, none in the quiet phase.
  initial begin
    out_stall_i = 1'b0;
    hold_left   = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else if (hold_req) begin
        hold_req    = 1'b0;
        hold_left   = HOLD_CYCLES;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !quiet && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // Monitor: track register writes, queue predictions, check results in order.
  always @(posedge clk_i) begin
    word_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          errors++;
          $display("%0t: result %h arrived with no expected value waiting", $time, result_o);
        end else begin
          want = pending_results.pop_front();
          if (result_o !== want) begin
            errors++;
            $display("%0t: result mismatch, expected %h, actual %h", $time, want, result_o);
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        pending_results.push_back(known_valid ? known_result
                                              : power_mod(base_i, model_exponent,
                                                          model_modulus));
      end
      if (cfg_valid_i && cfg_ready_o) begin
        cfg_writes++;
        case (cfg_index_i)
          REG_MODULUS:  model_modulus = cfg_data_i;
          REG_EXPONENT: model_exponent = cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Watchdog: too long without any transaction on any channel ends the run.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      silent_cycles = 0;
    end else begin
      silent_cycles++;
    end
    if (silent_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles, %0d results still owed",
               $time, WATCHDOG_LIMIT, pending_results.size());
      $display("modular_exponentiation regression: fail");
      $finish;
    end
  end

  // Main sequence: reset, directed table, random phases, drain and verdict.
  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    base_i         = '0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = REG_MODULUS;
    cfg_data_i     = '0;
    known_valid    = 1'b0;
    known_result   = '0;
    quiet          = 1'b0;
    hold_req       = 1'b0;
    items_accepted = 0;
    results_seen   = 0;
    cfg_writes     = 0;
    errors         = 0;
    silent_cycles  = 0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed table; consecutive register writes keep the write channel valid.
    for (int r = 0; r < PLAN_LEN; r++) begin
      if (directed_plan[r].is_cfg) begin
        if (r > 0 && !directed_plan[r-1].is_cfg) in_valid_i <= 1'b0;
        write_reg(directed_plan[r].index, directed_plan[r].value);
      end else begin
        if (r > 0 && directed_plan[r-1].is_cfg) cfg_valid_i <= 1'b0;
        offer_base(directed_plan[r].value, directed_plan[r].known,
                   directed_plan[r].result);
      end
    end
    in_valid_i <= 1'b0;

    // Random phases, each with its own modulus and exponent.
    for (int p = 0; p < NUM_PHASES; p++) begin
      quiet = (p == QUIET_PHASE);
      if ($urandom_range(3) == 0) begin
        write_reg($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B, word_t'($urandom));
      end
      write_reg(REG_MODULUS, pick_modulus(p));
      write_reg(REG_EXPONENT, pick_exponent(p));
      cfg_valid_i <= 1'b0;
      // Long receiver hold-off while bases keep coming, so the block backs up.
      if (p == HOLD_PHASE) hold_req = 1'b1;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // Halfway through one phase the sender waits for the block to empty.
        if (p == PAUSE_PHASE && n == ITEMS_PER_PHASE / 2) begin
          in_valid_i <= 1'b0;
          while (results_seen != items_accepted) @(posedge clk_i);
        end
        offer_base(pick_base(), 1'b0, '0);
      end
      in_valid_i <= 1'b0;
    end
    quiet = 1'b0;

    // Collect the remaining results, then watch for anything extra.
    while (results_seen != items_accepted) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Ran %0d bases through %0d register writes and checked %0d results,",
             items_accepted, cfg_writes, results_seen);
    $display("with moduli of one, 2^32 and near 2^32, zero and full exponents, stalls and idles.");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("modular_exponentiation regression: pass");
    end else begin
      $display("modular_exponentiation regression: fail");
    end
    $finish;
  end

endmodule
